// File: src/ppcc_pkg.sv
package ppcc_pkg;

    localparam int MAX_POINTS_DEF = 4096;
    localparam int COORD_BITS_DEF = 16;
    localparam int FIELD_W        = 16;
    localparam int OUT_W          = 48;
    localparam int IDX_W          = 4;

    // Result element indexes
    localparam logic [IDX_W-1:0] ELEM_FIRST     = 4'd0;
    localparam logic [IDX_W-1:0] ELEM_DST_FIRST = 4'd3;
    localparam logic [IDX_W-1:0] ELEM_COV_FIRST = 4'd6;
    localparam logic [IDX_W-1:0] ELEM_LAST      = 4'd14;

    typedef enum logic [3:0] {
        S_ACC,
        S_DIV1,
        S_WAIT1,
        S_MUL,
        S_DIV2,
        S_WAIT2,
        S_KCALC,
        S_OUT,
        S_HOLD
    } t_state;

    typedef enum logic {
        NUM_SUM,
        NUM_PROD
    } t_num_sel;

    typedef struct packed {
        logic             clear;
        logic             div_start;
        t_num_sel         num_sel;
        logic             save1;
        logic             save2;
        logic             mul;
        logic             kcalc;
        logic             out_load;
        logic [IDX_W-1:0] elem;
    } t_cmd;

    typedef struct packed {
        logic final_pend;
        logic final_acc;
        logic div_done;
        logic out_accept;
    } t_status;

    // Source axis of a covariance element
    function automatic logic [1:0] elem_row(input logic [IDX_W-1:0] e);
        logic [1:0] r;
        unique case (e)
            4'd9, 4'd10, 4'd11:  r = 2'd1;
            4'd12, 4'd13, 4'd14: r = 2'd2;
            default:             r = 2'd0;
        endcase
        return r;
    endfunction

    // Target axis of a covariance element
    function automatic logic [1:0] elem_col(input logic [IDX_W-1:0] e);
        logic [1:0] c;
        unique case (e)
            4'd7, 4'd10, 4'd13: c = 2'd1;
            4'd8, 4'd11, 4'd14: c = 2'd2;
            default:            c = 2'd0;
        endcase
        return c;
    endfunction

endpackage

// File: src/ppcc_div.sv
module ppcc_div #(
    parameter int DW = 32,
    parameter int NW = 13
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [DW-1:0] i_num,
    input  logic        [NW-1:0] i_den,
    output logic                 o_done,
    output logic signed [DW-1:0] o_quo,
    output logic        [NW-1:0] o_rem
);

    localparam int SCW = $clog2(DW + 1);

    logic           r_busy, r_fix, r_done, r_neg;
    logic [SCW-1:0] r_step;
    logic [NW-1:0]  r_rem;
    logic [DW-1:0]  r_quo;
    logic [DW-1:0]  r_q_out;
    logic [NW-1:0]  r_r_out;

    logic [NW:0]    n_shift;
    logic           n_bit;
    logic [NW-1:0]  n_rem;

    // One quotient bit per cycle on the magnitude
    always_comb begin
        n_shift = {r_rem, r_quo[DW-1]};
        n_bit   = (n_shift >= {1'b0, i_den});
        n_rem   = NW'(n_bit ? (n_shift - {1'b0, i_den}) : n_shift);
    end

    // Control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fix;
            r_fix  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == SCW'(1)) begin
                r_busy <= 1'b0;
                r_fix  <= 1'b1;
            end
        end
    end

    // Iterate, then turn the truncated result into a floor result
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg  <= i_num[DW-1];
            r_quo  <= i_num[DW-1] ? (~i_num + DW'(1)) : i_num;
            r_rem  <= '0;
            r_step <= SCW'(DW);
        end else if (r_busy) begin
            r_quo  <= {r_quo[DW-2:0], n_bit};
            r_rem  <= n_rem;
            r_step <= r_step - SCW'(1);
        end
        if (r_fix) begin
            if (!r_neg) begin
                r_q_out <= r_quo;
                r_r_out <= r_rem;
            end else if (r_rem == '0) begin
                r_q_out <= ~r_quo + DW'(1);
                r_r_out <= '0;
            end else begin
                r_q_out <= ~r_quo;
                r_r_out <= i_den - r_rem;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = signed'(r_q_out);
    assign o_rem  = r_r_out;

endmodule

// File: src/ppcc_dp.sv
module ppcc_dp #(
    parameter int MAX_POINTS = ppcc_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = ppcc_pkg::COORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ppcc_pkg::t_cmd                   i_cmd,
    output ppcc_pkg::t_status                o_st,
    input  logic                             i_in_accept,
    input  logic [ppcc_pkg::FIELD_W-1:0]     i_src_x,
    input  logic [ppcc_pkg::FIELD_W-1:0]     i_src_y,
    input  logic [ppcc_pkg::FIELD_W-1:0]     i_src_z,
    input  logic [ppcc_pkg::FIELD_W-1:0]     i_dst_x,
    input  logic [ppcc_pkg::FIELD_W-1:0]     i_dst_y,
    input  logic [ppcc_pkg::FIELD_W-1:0]     i_dst_z,
    input  logic                             i_final_pair,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output logic [ppcc_pkg::IDX_W-1:0]       o_element_index,
    output logic signed [ppcc_pkg::OUT_W-1:0] o_element_value,
    output logic                             o_run_end,
    output logic                             o_count_overflow
);

    localparam int CB  = COORD_BITS;
    localparam int NW  = $clog2(MAX_POINTS + 1);
    localparam int SW  = CB + NW;
    localparam int PW  = 2 * CB + NW;
    localparam int DW  = SW + NW + 1;
    localparam int KW  = 2 * SW + 2;
    localparam int VW  = (KW > ppcc_pkg::OUT_W) ? KW : ppcc_pkg::OUT_W;
    localparam int XW  = (CB > ppcc_pkg::FIELD_W) ? CB : ppcc_pkg::FIELD_W;

    // Input and product stages
    logic                 r_a_valid, r_a_final;
    logic signed [CB-1:0] r_a_p [3];
    logic signed [CB-1:0] r_a_q [3];
    logic                 r_b_valid, r_b_final;
    logic signed [2*CB-1:0] r_b_prod [9];
    logic signed [CB-1:0] r_b_p [3];
    logic signed [CB-1:0] r_b_q [3];

    // Accumulators
    logic signed [SW-1:0] r_src_sum [3];
    logic signed [SW-1:0] r_dst_sum [3];
    logic signed [PW-1:0] r_prod_sum [9];
    logic [NW-1:0]        r_cnt;
    logic                 r_ovf;

    // Division phase
    logic signed [DW-1:0]   r_a1;
    logic [NW-1:0]          r_r1;
    logic signed [DW-1:0]   r_m1;
    logic signed [2*SW-1:0] r_aq;
    logic signed [DW-1:0]   r_b2;
    logic [NW-1:0]          r_s2;
    logic signed [VW-1:0]   r_k;

    logic                       r_out_valid, r_out_ovf, r_out_end;
    logic [ppcc_pkg::IDX_W-1:0] r_out_idx;
    logic signed [VW-1:0]       r_out_val;

    logic [XW-1:0]        n_raw [6];
    logic signed [CB-1:0] n_crd [6];
    logic [1:0]           n_row, n_col;
    logic signed [SW-1:0] n_sum, n_sq;
    logic signed [DW-1:0] n_num;
    logic                 div_done;
    logic signed [DW-1:0] div_quo;
    logic [NW-1:0]        div_rem;
    logic signed [VW-1:0] n_base, n_val;
    logic [NW-1:0]        n_rr;
    logic [NW:0]          n_two_r, n_nn;
    logic                 out_accept;

    // Take the low coordinate bits and sign-extend them
    always_comb begin
        n_raw[0] = XW'(i_src_x);
        n_raw[1] = XW'(i_src_y);
        n_raw[2] = XW'(i_src_z);
        n_raw[3] = XW'(i_dst_x);
        n_raw[4] = XW'(i_dst_y);
        n_raw[5] = XW'(i_dst_z);
        for (int i = 0; i < 6; i++) begin
            n_crd[i] = signed'(n_raw[i][CB-1:0]);
        end
    end

    // Stage flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= i_in_accept;
            r_b_valid <= r_a_valid;
        end
    end

    // Capture item, then form the nine products
    always_ff @(posedge i_clk) begin
        if (i_in_accept) begin
            r_a_final <= i_final_pair;
            for (int i = 0; i < 3; i++) begin
                r_a_p[i] <= n_crd[i];
                r_a_q[i] <= n_crd[3 + i];
            end
        end
        r_b_final <= r_a_final;
        for (int i = 0; i < 3; i++) begin
            r_b_p[i] <= r_a_p[i];
            r_b_q[i] <= r_a_q[i];
            for (int j = 0; j < 3; j++) begin
                r_b_prod[i * 3 + j] <= r_a_p[i] * r_a_q[j];
            end
        end
    end

    // Accumulate, or drop the pair once the count is saturated
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_src_sum[i] <= '0;
                r_dst_sum[i] <= '0;
            end
            for (int i = 0; i < 9; i++) begin
                r_prod_sum[i] <= '0;
            end
        end else if (r_b_valid) begin
            if (r_cnt == NW'(MAX_POINTS)) begin
                r_ovf <= 1'b1;
            end else begin
                r_cnt <= r_cnt + NW'(1);
                for (int i = 0; i < 3; i++) begin
                    r_src_sum[i] <= r_src_sum[i] + SW'(r_b_p[i]);
                    r_dst_sum[i] <= r_dst_sum[i] + SW'(r_b_q[i]);
                end
                for (int i = 0; i < 9; i++) begin
                    r_prod_sum[i] <= r_prod_sum[i] + PW'(r_b_prod[i]);
                end
            end
        end
    end

    // Pick the sums for the current element
    always_comb begin
        n_row = ppcc_pkg::elem_row(i_cmd.elem);
        n_col = ppcc_pkg::elem_col(i_cmd.elem);
        n_sq  = r_dst_sum[n_col];
        if (i_cmd.elem < ppcc_pkg::ELEM_DST_FIRST) begin
            n_sum = r_src_sum[i_cmd.elem[1:0]];
        end else if (i_cmd.elem < ppcc_pkg::ELEM_COV_FIRST) begin
            n_sum = r_dst_sum[2'(i_cmd.elem - ppcc_pkg::ELEM_DST_FIRST)];
        end else begin
            n_sum = r_src_sum[n_row];
        end
        n_num = (i_cmd.num_sel == ppcc_pkg::NUM_PROD) ? r_m1 : DW'(n_sum);
    end

    ppcc_div #(
        .DW (DW),
        .NW (NW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (n_num),
        .i_den   (r_cnt),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    // Hold the partial results of the covariance steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.save1) begin
            r_a1 <= div_quo;
            r_r1 <= div_rem;
        end
        if (i_cmd.mul) begin
            r_m1 <= DW'(signed'({1'b0, r_r1})) * DW'(n_sq);
            r_aq <= signed'(r_a1[SW-1:0]) * n_sq;
        end
        if (i_cmd.save2) begin
            r_b2 <= div_quo;
            r_s2 <= div_rem;
        end
        if (i_cmd.kcalc) begin
            r_k <= VW'(r_prod_sum[4'(i_cmd.elem - ppcc_pkg::ELEM_COV_FIRST)])
                 - VW'(r_aq) - VW'(r_b2);
        end
    end

    // Round to nearest, ties away from zero
    always_comb begin
        if (i_cmd.elem < ppcc_pkg::ELEM_COV_FIRST) begin
            n_base = VW'(r_a1);
            n_rr   = r_r1;
        end else begin
            n_base = r_k - VW'(1);
            n_rr   = r_cnt - r_s2;
        end
        n_two_r = {n_rr, 1'b0};
        n_nn    = {1'b0, r_cnt};
        if (i_cmd.elem >= ppcc_pkg::ELEM_COV_FIRST && r_s2 == '0) begin
            n_val = r_k;
        end else if (n_two_r < n_nn) begin
            n_val = n_base;
        end else if (n_two_r > n_nn) begin
            n_val = n_base + VW'(1);
        end else begin
            n_val = n_base[VW-1] ? n_base : (n_base + VW'(1));
        end
    end

    assign out_accept = r_out_valid && !i_out_stall;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (out_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_val <= n_val;
            r_out_idx <= i_cmd.elem;
            r_out_end <= (i_cmd.elem == ppcc_pkg::ELEM_LAST);
            r_out_ovf <= r_ovf;
        end
    end

    assign o_st.final_pend = (r_a_valid && r_a_final) || (r_b_valid && r_b_final);
    assign o_st.final_acc  = r_b_valid && r_b_final;
    assign o_st.div_done   = div_done;
    assign o_st.out_accept = out_accept;

    assign o_out_valid      = r_out_valid;
    assign o_element_index  = r_out_idx;
    assign o_element_value  = signed'(r_out_val[ppcc_pkg::OUT_W-1:0]);
    assign o_run_end        = r_out_end;
    assign o_count_overflow = r_out_ovf;

endmodule

// File: src/ppcc_ctrl.sv
module ppcc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ppcc_pkg::t_status i_st,
    output ppcc_pkg::t_cmd    o_cmd,
    output logic              o_in_stall
);

    ppcc_pkg::t_state           r_state, n_state;
    logic [ppcc_pkg::IDX_W-1:0] r_elem, n_elem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppcc_pkg::S_ACC;
            r_elem  <= ppcc_pkg::ELEM_FIRST;
        end else begin
            r_state <= n_state;
            r_elem  <= n_elem;
        end
    end

    // Sequence the fifteen results of a cloud
    always_comb begin
        n_state       = r_state;
        n_elem        = r_elem;
        o_cmd         = '0;
        o_cmd.elem    = r_elem;
        o_cmd.num_sel = ppcc_pkg::NUM_SUM;
        unique case (r_state)
            ppcc_pkg::S_ACC: begin
                if (i_st.final_acc) n_state = ppcc_pkg::S_DIV1;
            end
            ppcc_pkg::S_DIV1: begin
                o_cmd.div_start = 1'b1;
                n_state         = ppcc_pkg::S_WAIT1;
            end
            ppcc_pkg::S_WAIT1: begin
                if (i_st.div_done) begin
                    o_cmd.save1 = 1'b1;
                    n_state = (r_elem < ppcc_pkg::ELEM_COV_FIRST) ?
                              ppcc_pkg::S_OUT : ppcc_pkg::S_MUL;
                end
            end
            ppcc_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ppcc_pkg::S_DIV2;
            end
            ppcc_pkg::S_DIV2: begin
                o_cmd.div_start = 1'b1;
                o_cmd.num_sel   = ppcc_pkg::NUM_PROD;
                n_state         = ppcc_pkg::S_WAIT2;
            end
            ppcc_pkg::S_WAIT2: begin
                if (i_st.div_done) begin
                    o_cmd.save2 = 1'b1;
                    n_state     = ppcc_pkg::S_KCALC;
                end
            end
            ppcc_pkg::S_KCALC: begin
                o_cmd.kcalc = 1'b1;
                n_state     = ppcc_pkg::S_OUT;
            end
            ppcc_pkg::S_OUT: begin
                o_cmd.out_load = 1'b1;
                n_state        = ppcc_pkg::S_HOLD;
            end
            ppcc_pkg::S_HOLD: begin
                if (i_st.out_accept) begin
                    if (r_elem == ppcc_pkg::ELEM_LAST) begin
                        o_cmd.clear = 1'b1;
                        n_elem      = ppcc_pkg::ELEM_FIRST;
                        n_state     = ppcc_pkg::S_ACC;
                    end else begin
                        n_elem  = r_elem + ppcc_pkg::IDX_W'(1);
                        n_state = ppcc_pkg::S_DIV1;
                    end
                end
            end
            default: begin
                n_state = ppcc_pkg::S_ACC;
            end
        endcase
    end

    // Hold input while a final pair is in flight or results are pending
    assign o_in_stall = (r_state != ppcc_pkg::S_ACC) || i_st.final_pend;

endmodule

// File: src/point_pair_cross_covariance.sv
// Accumulation: one pair per cycle while input is not stalled; an accepted pair is
// captured, multiplied into nine products, then added to the sums. A final pair
// stalls input until all 15 results are taken. Each result runs the shared
// bit-serial divider (SW+NW+1 quotient bits per pass, one or two passes).
// Reset: synchronous, active low; clears sums, count, overflow and control.
module point_pair_cross_covariance #(
    parameter int MAX_POINTS = ppcc_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = ppcc_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ppcc_pkg::FIELD_W-1:0]      i_src_x,
    input  logic [ppcc_pkg::FIELD_W-1:0]      i_src_y,
    input  logic [ppcc_pkg::FIELD_W-1:0]      i_src_z,
    input  logic [ppcc_pkg::FIELD_W-1:0]      i_dst_x,
    input  logic [ppcc_pkg::FIELD_W-1:0]      i_dst_y,
    input  logic [ppcc_pkg::FIELD_W-1:0]      i_dst_z,
    input  logic                              i_final_pair,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ppcc_pkg::IDX_W-1:0]        o_element_index,
    output logic signed [ppcc_pkg::OUT_W-1:0] o_element_value,
    output logic                              o_run_end,
    output logic                              o_count_overflow
);

    ppcc_pkg::t_cmd    cmd;
    ppcc_pkg::t_status st;
    logic              in_accept;

    assign in_accept = i_in_valid && !o_in_stall;

    ppcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_st       (st),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    ppcc_dp #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_st             (st),
        .i_in_accept      (in_accept),
        .i_src_x          (i_src_x),
        .i_src_y          (i_src_y),
        .i_src_z          (i_src_z),
        .i_dst_x          (i_dst_x),
        .i_dst_y          (i_dst_y),
        .i_dst_z          (i_dst_z),
        .i_final_pair     (i_final_pair),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_element_index  (o_element_index),
        .o_element_value  (o_element_value),
        .o_run_end        (o_run_end),
        .o_count_overflow (o_count_overflow)
    );

`ifndef NO_ASSERTIONS
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while a result is pending");

    a_end_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_run_end && o_out_valid |-> o_element_index == ppcc_pkg::ELEM_LAST)
        else $error("run end on wrong element");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall |=> !o_out_valid)
        else $error("result reloaded without a compute step");

    a_final_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st.final_acc |=> cmd.div_start)
        else $error("final pair did not start the division phase");
`endif

endmodule
